// ===== hdl/q8bsd_pkg.sv =====
package q8bsd_pkg;

	localparam logic [31:0] QNAN = 32'h7FC0_0000;

	// fp32 multiply, split across two register stages
	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sign;
		logic signed [10:0] e;
		logic [47:0]        p;
	} fmul_mid_t;

	// fp32 add, split across two register stages
	typedef struct packed {
		logic        nan;
		logic        inf;
		logic        sign;
		logic        both_neg;
		logic [7:0]  e;
		logic [27:0] sum;
	} fadd_mid_t;

	function automatic logic [31:0] h2f(logic [15:0] h);
		logic [4:0]  ex;
		logic [9:0]  man;
		logic [7:0]  e;
		logic [31:0] r;
		ex  = h[14:10];
		man = h[9:0];
		e   = 8'd0;
		r   = {h[15], 31'd0};
		if (ex == 5'd0) begin
			if (man != 10'd0) begin
				// subnormal half: highest set bit becomes the hidden one
				for (int i = 0; i < 10; i++) begin
					if (man[i]) begin
						e = 8'(103 + i);
					end
				end
				r = {h[15], e, 23'((24'(man) << (8'd113 - e)) & 24'h3FF) << 13};
			end
		end else if (ex == 5'd31) begin
			r = {h[15], 8'hFF, man, 13'd0};
		end else begin
			r = {h[15], 8'(ex) + 8'd112, man, 13'd0};
		end
		return r;
	endfunction

	// exact: magnitude never exceeds 24 bits
	function automatic logic [31:0] i2f(logic signed [23:0] v);
		logic [23:0] mag;
		logic [4:0]  p;
		logic [23:0] sh;
		mag = v[23] ? 24'(-v) : 24'(v);
		p   = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (mag[i]) begin
				p = 5'(i);
			end
		end
		sh = mag << (5'd23 - p);
		if (mag == 24'd0) begin
			return 32'd0;
		end
		return {v[23], 8'd127 + 8'(p), sh[22:0]};
	endfunction

	function automatic fmul_mid_t fmul_a(logic [31:0] a, logic [31:0] b);
		fmul_mid_t  r;
		logic [7:0] ea;
		logic [7:0] eb;
		logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		ea     = a[30:23];
		eb     = b[30:23];
		a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
		b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
		a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
		b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (ea == 8'd0) && (a[22:0] == 23'd0);
		b_zero = (eb == 8'd0) && (b[22:0] == 23'd0);
		r.sign = a[31] ^ b[31];
		r.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
		r.inf  = a_inf | b_inf;
		r.zero = a_zero | b_zero;
		r.e    = 11'((ea == 8'd0) ? 8'd1 : ea) + 11'((eb == 8'd0) ? 8'd1 : eb) - 11'd127;
		r.p    = 48'({ea != 8'd0, a[22:0]}) * 48'({eb != 8'd0, b[22:0]});
		return r;
	endfunction

	function automatic logic [31:0] fmul_b(fmul_mid_t m);
		logic [5:0]         lz;
		logic [47:0]        pn;
		logic [47:0]        sv;
		logic signed [11:0] rr;
		logic [11:0]        shamt;
		logic               lost;
		logic [7:0]         ef;
		logic               g, st, inc;
		lz = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (m.p[i]) begin
				lz = 6'(47 - i);
			end
		end
		pn    = m.p << lz;
		rr    = {m.e[10], m.e} + 12'sd1 - $signed({6'd0, lz});
		shamt = 12'd0;
		sv    = pn;
		lost  = 1'b0;
		ef    = rr[7:0];
		if (rr <= 12'sd0) begin
			ef    = 8'd0;
			shamt = 12'(12'sd1 - rr);
			if (shamt >= 12'd48) begin
				sv   = 48'd0;
				lost = 1'b1;
			end else begin
				sv   = pn >> shamt;
				lost = |(pn & ~({48{1'b1}} << shamt));
			end
		end
		g   = sv[23];
		st  = (|sv[22:0]) | lost;
		inc = g & (st | sv[24]);
		if (m.nan) begin
			return QNAN;
		end
		if (m.inf || rr >= 12'sd255) begin
			return {m.sign, 8'hFF, 23'd0};
		end
		if (m.zero) begin
			return {m.sign, 31'd0};
		end
		return {m.sign, {ef, sv[46:24]} + 31'(inc)};
	endfunction

	function automatic fadd_mid_t fadd_a(logic [31:0] a, logic [31:0] b);
		fadd_mid_t   r;
		logic [31:0] bg;
		logic [31:0] sm;
		logic [7:0]  eg, es, d;
		logic [26:0] bg27, sm27, al;
		logic        a_nan, b_nan, a_inf, b_inf;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		if (a[30:0] >= b[30:0]) begin
			bg = a;
			sm = b;
		end else begin
			bg = b;
			sm = a;
		end
		eg   = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
		es   = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
		d    = eg - es;
		bg27 = {bg[30:23] != 8'd0, bg[22:0], 3'd0};
		sm27 = {sm[30:23] != 8'd0, sm[22:0], 3'd0};
		if (d >= 8'd27) begin
			al = {26'd0, |sm27};
		end else begin
			al = (sm27 >> d) | {26'd0, |(sm27 & ~({27{1'b1}} << d))};
		end
		r.nan      = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
		r.inf      = a_inf | b_inf;
		r.sign     = (a_inf | b_inf) ? (a_inf ? a[31] : b[31]) : bg[31];
		r.both_neg = a[31] & b[31];
		r.e        = eg;
		r.sum      = (bg[31] == sm[31]) ? ({1'b0, bg27} + {1'b0, al})
			: ({1'b0, bg27} - {1'b0, al});
		return r;
	endfunction

	function automatic logic [31:0] fadd_b(fadd_mid_t m);
		logic [8:0]  e9;
		logic [26:0] s;
		logic [4:0]  lz;
		logic [7:0]  sh;
		logic [7:0]  ef;
		logic        g, st, inc;
		lz = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (m.sum[i]) begin
				lz = 5'(26 - i);
			end
		end
		if (m.sum[27]) begin
			s  = m.sum[27:1] | {26'd0, m.sum[0]};
			e9 = 9'(m.e) + 9'd1;
		end else begin
			sh = (8'(lz) > m.e - 8'd1) ? m.e - 8'd1 : 8'(lz);
			s  = m.sum[26:0] << sh;
			e9 = 9'(m.e) - 9'(sh);
		end
		ef  = s[26] ? e9[7:0] : 8'd0;
		g   = s[2];
		st  = s[1] | s[0];
		inc = g & (st | s[3]);
		if (m.nan) begin
			return QNAN;
		end
		if (m.inf || e9 >= 9'd255) begin
			return {m.sign, 8'hFF, 23'd0};
		end
		if (m.sum == 28'd0) begin
			return {m.both_neg, 31'd0};
		end
		return {m.sign, {ef, s[25:3]} + 31'(inc)};
	endfunction

endpackage

// ===== hdl/q8bsd_lanes.sv =====
module q8bsd_lanes #(
	parameter int CHUNK_ELEMS = 8
) (
	input  logic [63:0] weight_bytes,
	input  logic [63:0] act_bytes,
	output logic signed [$clog2(CHUNK_ELEMS * 16384 + 1):0] dot
);
	localparam int DOT_W = $clog2(CHUNK_ELEMS * 16384 + 1) + 1;

	logic signed [15:0] prod [CHUNK_ELEMS];

	// one 8x8 signed multiplier per lane
	for (genvar k = 0; k < CHUNK_ELEMS; k++) begin : g_lane
		assign prod[k] = $signed(weight_bytes[8*k +: 8]) * $signed(act_bytes[8*k +: 8]);
	end

	// merge lane products
	always_comb begin
		dot = '0;
		for (int k = 0; k < CHUNK_ELEMS; k++) begin
			dot = dot + DOT_W'(prod[k]);
		end
	end

endmodule

// ===== hdl/q8_block_scaled_dot_unit.sv =====
// Q8_0 block dot product: eight int8 lanes feed an exact block sum, fp32 scaling per block.
// Throughput: one transfer every cycle while the block is not busy; the last item of a
//   block holds the input off while two fp32 multiplies and one fp32 add run (each in a
//   multiply/add stage and a normalise/round stage, sharing one sequencer) and, at a
//   row end, until the output register is free to take the registered row sum.
// Reset: arst_n clears the block sum, item counter, row accumulator (+0.0) and out valid.
module q8_block_scaled_dot_unit #(
	parameter int BLOCK_ELEMS = 32,
	parameter int CHUNK_ELEMS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] weight_bytes,
	input  logic [63:0] act_bytes,
	input  logic [15:0] weight_scale,
	input  logic [31:0] act_scale,
	input  logic        end_of_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] row_sum
);
	import q8bsd_pkg::*;

	localparam int CPB_RAW = BLOCK_ELEMS / CHUNK_ELEMS;
	localparam int CPB     = (CPB_RAW < 1) ? 1 : CPB_RAW;   // items per block
	localparam int CNT_W   = (CPB > 1) ? $clog2(CPB) : 1;
	localparam int ELEMS   = CPB * CHUNK_ELEMS;
	localparam int SUM_W   = $clog2(ELEMS * 16384 + 1) + 1;  // 21 bits at the defaults; i2f takes at most 24
	localparam int DOT_W   = $clog2(CHUNK_ELEMS * 16384 + 1) + 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;  // scale multiply, int to float
	localparam logic [2:0] ST_RND1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;  // block sum times scale
	localparam logic [2:0] ST_RND2 = 3'd4;
	localparam logic [2:0] ST_ADD  = 3'd5;  // into the row accumulator
	localparam logic [2:0] ST_RND3 = 3'd6;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        chunk_q;
	logic signed [SUM_W-1:0] bsum_q;
	logic signed [SUM_W-1:0] bfin_q;
	logic [15:0]             ws_q;
	logic [31:0]             as_q;
	logic                    eor_q;
	fmul_mid_t               mmid_q;
	fadd_mid_t               amid_q;
	logic [31:0]             fdot_q;
	logic [31:0]             scale_q;
	logic [31:0]             prod_q;
	logic [31:0]             acc_q;
	logic                    out_valid_q;
	logic [31:0]             row_sum_q;

	logic signed [DOT_W-1:0] dot;
	logic signed [SUM_W-1:0] nsum;
	logic                    in_xfer;
	logic                    last;
	logic                    out_free;
	logic [31:0]             add_res;

	q8bsd_lanes #(
		.CHUNK_ELEMS(CHUNK_ELEMS)
	) u_lanes (
		.weight_bytes(weight_bytes),
		.act_bytes   (act_bytes),
		.dot         (dot)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign last      = (chunk_q == CNT_W'(CPB - 1));
	assign nsum      = bsum_q + SUM_W'(dot);
	assign out_free  = !out_valid_q || !out_stall;
	assign add_res   = fadd_b(amid_q);
	assign out_valid = out_valid_q;
	assign row_sum   = row_sum_q;

	// control and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= '0;
			bsum_q      <= '0;
			acc_q       <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			// a row end in the last stage refills the output itself
			if (out_valid_q && !out_stall && !(state_q == ST_RND3 && eor_q)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (last) begin
							bsum_q  <= '0;
							chunk_q <= '0;
							state_q <= ST_MUL1;
						end else begin
							bsum_q  <= nsum;
							chunk_q <= chunk_q + CNT_W'(1);
						end
					end
				end
				ST_MUL1: state_q <= ST_RND1;
				ST_RND1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_RND2;
				ST_RND2: state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_RND3;
				ST_RND3: begin
					// row end waits here until the output register can take the sum
					if (!eor_q) begin
						acc_q   <= add_res;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						acc_q       <= 32'd0;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && last) begin
					bfin_q <= nsum;
					ws_q   <= weight_scale;
					as_q   <= act_scale;
					eor_q  <= end_of_row;
				end
			end
			ST_MUL1: begin
				mmid_q <= fmul_a(h2f(ws_q), as_q);
				fdot_q <= i2f(24'(bfin_q));
			end
			ST_RND1: scale_q <= fmul_b(mmid_q);
			ST_MUL2: mmid_q  <= fmul_a(fdot_q, scale_q);
			ST_RND2: prod_q  <= fmul_b(mmid_q);
			ST_ADD:  amid_q  <= fadd_a(acc_q, prod_q);
			ST_RND3: begin
				if (eor_q && out_free) begin
					row_sum_q <= add_res;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/q8bsd_checker.sv =====
module q8bsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] row_sum
);

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_sum))
		else $error("row_sum changed while stalled");

	// a NaN leaves only in canonical form
	a_qnan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_sum[30:23] == 8'hFF && row_sum[22:0] != 23'd0
		|-> row_sum == 32'h7FC0_0000)
		else $error("non-canonical NaN on row_sum");

	// a new result only comes out of the busy float sequence
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without float sequence");

endmodule

bind q8_block_scaled_dot_unit q8bsd_checker u_q8bsd_checker (.*);
